// ===== src/dto_pkg.sv =====
package dto_pkg;

    localparam int FIELD_W  = 5;
    localparam int OP_W     = 2;
    localparam int CFG_W    = 6;
    localparam int PEND_W   = 6;
    localparam int EDGE_W   = 2 * FIELD_W;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        ST_ORDER    = 3'd0,
        ST_EMPTY_OK = 3'd1,
        ST_CYCLE    = 3'd2,
        ST_FULL     = 3'd3,
        ST_ADDED    = 3'd4,
        ST_DUP      = 3'd5,
        ST_RANGE    = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    typedef enum logic {
        CMD_REPORT,
        CMD_COMPUTE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_status   status;
    } t_cmd;

endpackage

// ===== src/dto_if.sv =====
interface dto_in_if;
    import dto_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [FIELD_W-1:0] provider;
    logic [FIELD_W-1:0] consumer;

    modport source (output valid, operation, provider, consumer, input ready);
    modport sink   (input valid, operation, provider, consumer, output ready);
endinterface

interface dto_out_if;
    import dto_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] module_res;
    logic [FIELD_W-1:0] cycle_provider;
    logic [FIELD_W-1:0] cycle_consumer;
    logic               last;

    modport source (output valid, status, position, module_res, cycle_provider,
                    cycle_consumer, last, input ready);
    modport sink   (input valid, status, position, module_res, cycle_provider,
                    cycle_consumer, last, output ready);
endinterface

// ===== src/dependency_topological_order.sv =====
// Channel   Dir  Handshake      Payload
// i_item    in   valid/ready    operation, provider, consumer
// o_result  out  valid/ready    status, position, module_res, cycle_provider,
//                               cycle_consumer, last
// i_cfg_*   in   write enable   module_count (6 bit)
//
// Add, clear and the short-cut compute outcomes stream one transaction per cycle
// while o_result is ready. A full compute runs from acceptance through a queue pop,
// an in-degree RAM sweep over the E stored edges, a pick and an apply step per placed
// module (n modules), a final pick and the emit. A cycle report adds a second sweep.
// Order entries then stream one per cycle while o_result is ready.
// Input stalls while a compute is in flight or the two-entry command queue is full;
// reset is synchronous, active low; the edge RAM needs no clearing pass.
module dependency_topological_order #(
    parameter int MAX_MODULES = 32,
    parameter int MAX_EDGES   = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dto_in_if.sink                    i_item,
    dto_out_if.source                 o_result,
    input  logic                      i_cfg_we,
    input  logic [dto_pkg::CFG_W-1:0] i_cfg_wdata
);
    import dto_pkg::*;

    localparam int MW = $clog2(MAX_MODULES);
    localparam int NW = $clog2(MAX_MODULES + 1);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int SW = $clog2(MAX_EDGES + 1);

    logic [CFG_W-1:0]       r_module_count;
    logic [NW-1:0]          w_n;

    logic                   w_cmd_push;
    logic                   w_push_ready;
    t_cmd                   w_cmd_in;
    logic                   w_pop_valid;
    logic                   w_pop_ready;
    t_cmd                   w_cmd_out;

    logic                   w_edge_we;
    logic [EW-1:0]          w_edge_waddr;
    logic [EDGE_W-1:0]      w_edge_wdata;
    logic [EW-1:0]          w_edge_raddr;
    logic [EDGE_W-1:0]      w_edge_rdata;
    logic [SW-1:0]          w_edges_stored;
    logic [MW-1:0]          w_adj_addr;
    logic [MAX_MODULES-1:0] w_adj_row;
    logic                   w_done;
    logic                   w_busy;

    // module count register; active count clamps to the build-time maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= '0;
        end else if (i_cfg_we) begin
            r_module_count <= i_cfg_wdata;
        end
    end

    assign w_n = (32'(r_module_count) > MAX_MODULES) ? NW'(MAX_MODULES)
                                                     : NW'(r_module_count);

    // front end: classifies each transaction, owns the edge list and rows
    dto_front #(
        .MAX_MODULES (MAX_MODULES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_n            (w_n),
        .o_cmd_valid    (w_cmd_push),
        .i_cmd_ready    (w_push_ready),
        .o_cmd          (w_cmd_in),
        .o_edge_we      (w_edge_we),
        .o_edge_waddr   (w_edge_waddr),
        .o_edge_wdata   (w_edge_wdata),
        .o_edges_stored (w_edges_stored),
        .i_adj_addr     (w_adj_addr),
        .o_adj_row      (w_adj_row),
        .i_done         (w_done),
        .o_busy         (w_busy)
    );

    dto_cmd_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_cmd_push),
        .i_cmd        (w_cmd_in),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop_ready),
        .o_cmd        (w_cmd_out)
    );

    // stored edges, written by the front end, swept by the back end
    dto_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (w_edge_waddr),
        .i_wdata (w_edge_wdata),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rdata)
    );

    // back end: Kahn ordering and result streaming
    dto_back #(
        .MAX_MODULES (MAX_MODULES),
        .MAX_EDGES   (MAX_EDGES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_n            (w_n),
        .i_cmd_valid    (w_pop_valid),
        .o_cmd_ready    (w_pop_ready),
        .i_cmd          (w_cmd_out),
        .o_edge_raddr   (w_edge_raddr),
        .i_edge_rdata   (w_edge_rdata),
        .i_edges_stored (w_edges_stored),
        .o_adj_addr     (w_adj_addr),
        .i_adj_row      (w_adj_row),
        .o_done         (w_done),
        .o_result       (o_result)
    );

`ifndef SYNTHESIS
    // a compute completion only arrives while the front end waits for one
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_busy)
        else $error("compute done without a compute in flight");

    // no edge lands in the store while a compute sweeps it
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_edge_we)
        else $error("edge write during compute");

    // single-result outcomes always close their transaction
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_ORDER) |-> o_result.last)
        else $error("non-order result without last");

    // cycle fields are zero except on a cycle report
    a_cycle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_CYCLE)
            |-> (o_result.cycle_provider == '0 && o_result.cycle_consumer == '0))
        else $error("cycle fields set on non-cycle result");
`endif
endmodule

// ===== src/dto_ram.sv =====
module dto_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/dto_cmd_fifo.sv =====
module dto_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dto_pkg::t_cmd i_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output dto_pkg::t_cmd o_cmd
);
    import dto_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_cmd        = r_mem[r_rptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// ===== src/dto_front.sv =====
module dto_front #(
    parameter int MAX_MODULES = 32,
    parameter int MAX_EDGES   = 256,
    localparam int MW = $clog2(MAX_MODULES),
    localparam int NW = $clog2(MAX_MODULES + 1),
    localparam int EW = $clog2(MAX_EDGES),
    localparam int SW = $clog2(MAX_EDGES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dto_in_if.sink                    i_item,
    input  logic [NW-1:0]             i_n,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output dto_pkg::t_cmd             o_cmd,
    output logic                      o_edge_we,
    output logic [EW-1:0]             o_edge_waddr,
    output logic [dto_pkg::EDGE_W-1:0] o_edge_wdata,
    output logic [SW-1:0]             o_edges_stored,
    input  logic [MW-1:0]             i_adj_addr,
    output logic [MAX_MODULES-1:0]    o_adj_row,
    input  logic                      i_done,
    output logic                      o_busy
);
    import dto_pkg::*;

    logic [MAX_MODULES-1:0] r_adj [MAX_MODULES];
    logic [SW-1:0]          r_stored;
    logic                   r_ovf;
    logic                   r_busy;

    logic          w_accept;
    logic [MW-1:0] w_p;
    logic [MW-1:0] w_c;
    logic [MW-1:0] w_raddr;
    logic          w_range;
    logic          w_dup;
    logic          w_full;
    t_cmd          w_cmd;
    logic          w_push;

    assign w_p      = MW'(i_item.provider);
    assign w_c      = MW'(i_item.consumer);
    // one row port: the back end owns it while a compute runs
    assign w_raddr  = r_busy ? i_adj_addr : w_p;
    assign o_adj_row = r_adj[w_raddr];

    assign w_range = (32'(i_item.provider) >= 32'(i_n)) || (32'(i_item.consumer) >= 32'(i_n));
    assign w_dup   = o_adj_row[w_c];
    assign w_full  = (r_stored >= SW'(MAX_EDGES));

    assign i_item.ready = !r_busy && i_cmd_ready;
    assign w_accept     = i_item.valid && i_item.ready;

    always_comb begin
        w_cmd  = '{kind: CMD_REPORT, status: ST_CLEARED};
        w_push = 1'b0;
        unique case (i_item.operation)
            OP_ADD: begin
                w_push = 1'b1;
                if (w_range) begin
                    w_cmd.status = ST_RANGE;
                end else if (w_dup) begin
                    w_cmd.status = ST_DUP;
                end else if (w_full) begin
                    w_cmd.status = ST_FULL;
                end else begin
                    w_cmd.status = ST_ADDED;
                end
            end
            OP_COMPUTE: begin
                w_push = 1'b1;
                if (i_n == '0) begin
                    w_cmd.status = ST_EMPTY_OK;
                end else if (r_ovf) begin
                    w_cmd.status = ST_FULL;
                end else begin
                    w_cmd.kind = CMD_COMPUTE;
                end
            end
            OP_CLEAR: begin
                w_push = 1'b1;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    assign o_cmd_valid    = w_accept && w_push;
    assign o_cmd          = w_cmd;
    assign o_edge_we      = w_accept && w_push && (w_cmd.status == ST_ADDED);
    assign o_edge_waddr   = r_stored[EW-1:0];
    assign o_edge_wdata   = {i_item.provider, i_item.consumer};
    assign o_edges_stored = r_stored;
    assign o_busy         = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MODULES; i++) begin
                r_adj[i] <= '0;
            end
            r_stored <= '0;
            r_ovf    <= 1'b0;
            r_busy   <= 1'b0;
        end else begin
            if (i_done) begin
                r_busy <= 1'b0;
            end
            if (w_accept && w_push) begin
                if (w_cmd.kind == CMD_COMPUTE) begin
                    r_busy <= 1'b1;
                end
                if (i_item.operation == OP_CLEAR) begin
                    for (int i = 0; i < MAX_MODULES; i++) begin
                        r_adj[i] <= '0;
                    end
                    r_stored <= '0;
                    r_ovf    <= 1'b0;
                end
                if (i_item.operation == OP_ADD && w_cmd.status == ST_FULL) begin
                    r_ovf <= 1'b1;
                end
                if (o_edge_we) begin
                    r_adj[w_p][w_c] <= 1'b1;
                    r_stored        <= r_stored + SW'(1);
                end
            end
        end
    end
endmodule

// ===== src/dto_back.sv =====
module dto_back #(
    parameter int MAX_MODULES = 32,
    parameter int MAX_EDGES   = 256,
    localparam int MW = $clog2(MAX_MODULES),
    localparam int NW = $clog2(MAX_MODULES + 1),
    localparam int EW = $clog2(MAX_EDGES),
    localparam int SW = $clog2(MAX_EDGES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [NW-1:0]              i_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_ready,
    input  dto_pkg::t_cmd              i_cmd,
    output logic [EW-1:0]              o_edge_raddr,
    input  logic [dto_pkg::EDGE_W-1:0] i_edge_rdata,
    input  logic [SW-1:0]              i_edges_stored,
    output logic [MW-1:0]              o_adj_addr,
    input  logic [MAX_MODULES-1:0]     i_adj_row,
    output logic                       o_done,
    dto_out_if.source                  o_result
);
    import dto_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_COUNT, S_PICK, S_APPLY, S_FIND, S_FOUT, S_EMIT
    } t_state;

    t_state                 r_state;
    logic [PEND_W-1:0]      r_pend [MAX_MODULES];
    logic [MAX_MODULES-1:0] r_placed;
    logic [MW-1:0]          r_order [MAX_MODULES];
    logic [MW-1:0]          r_sel;
    logic [NW-1:0]          r_pos;
    logic [SW-1:0]          r_addr;
    logic                   r_vld;
    logic [FIELD_W-1:0]     r_cp;
    logic [FIELD_W-1:0]     r_cc;
    logic                   r_done;

    logic                   r_ovalid;
    t_status                r_ostatus;
    logic [FIELD_W-1:0]     r_opos;
    logic [FIELD_W-1:0]     r_omod;
    logic [FIELD_W-1:0]     r_ocp;
    logic [FIELD_W-1:0]     r_occ;
    logic                   r_olast;

    logic               w_free;
    logic               w_found;
    logic [MW-1:0]      w_sel;
    logic [FIELD_W-1:0] w_from;
    logic [FIELD_W-1:0] w_to;
    logic               w_in_rng;
    logic               w_issue;
    logic               w_last;

    assign w_free       = !r_ovalid || o_result.ready;
    assign o_cmd_ready  = (r_state == S_IDLE) && (i_cmd.kind == CMD_COMPUTE || w_free);
    assign o_edge_raddr = r_addr[EW-1:0];
    assign o_adj_addr   = r_sel;
    assign o_done       = r_done;
    assign w_from       = i_edge_rdata[EDGE_W-1:FIELD_W];
    assign w_to         = i_edge_rdata[FIELD_W-1:0];
    assign w_in_rng     = (32'(w_from) < 32'(i_n)) && (32'(w_to) < 32'(i_n));
    assign w_issue      = (r_addr < i_edges_stored);
    assign w_last       = (32'(r_pos) + 32'd1 == 32'(i_n));

    // lowest unplaced module with no pending providers
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = MAX_MODULES - 1; i >= 0; i--) begin
            if (i < 32'(i_n) && !r_placed[i] && r_pend[i] == '0) begin
                w_found = 1'b1;
                w_sel   = MW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_done   <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        if (i_cmd.kind == CMD_COMPUTE) begin
                            for (int i = 0; i < MAX_MODULES; i++) begin
                                r_pend[i] <= '0;
                            end
                            r_placed <= '0;
                            r_addr   <= '0;
                            r_vld    <= 1'b0;
                            r_state  <= S_COUNT;
                        end else begin
                            r_ovalid  <= 1'b1;
                            r_ostatus <= i_cmd.status;
                            r_opos    <= '0;
                            r_omod    <= '0;
                            r_ocp     <= '0;
                            r_occ     <= '0;
                            r_olast   <= 1'b1;
                        end
                    end
                end
                S_COUNT: begin
                    r_vld <= w_issue;
                    if (w_issue) begin
                        r_addr <= r_addr + SW'(1);
                    end
                    if (r_vld && w_in_rng) begin
                        r_pend[MW'(w_to)] <= r_pend[MW'(w_to)] + PEND_W'(1);
                    end
                    if (!r_vld && !w_issue) begin
                        r_pos   <= '0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_pos == i_n) begin
                        r_pos   <= '0;
                        r_state <= S_EMIT;
                    end else if (w_found) begin
                        r_order[r_pos[MW-1:0]] <= w_sel;
                        r_placed[w_sel]        <= 1'b1;
                        r_sel                  <= w_sel;
                        r_pos                  <= r_pos + NW'(1);
                        r_state                <= S_APPLY;
                    end else begin
                        r_addr  <= '0;
                        r_vld   <= 1'b0;
                        r_cp    <= '0;
                        r_cc    <= '0;
                        r_state <= S_FIND;
                    end
                end
                S_APPLY: begin
                    for (int j = 0; j < MAX_MODULES; j++) begin
                        if (i_adj_row[j] && !r_placed[j] && r_pend[j] != '0) begin
                            r_pend[j] <= r_pend[j] - PEND_W'(1);
                        end
                    end
                    r_state <= S_PICK;
                end
                S_FIND: begin
                    r_vld <= w_issue;
                    if (w_issue) begin
                        r_addr <= r_addr + SW'(1);
                    end
                    if (r_vld && w_in_rng && !r_placed[MW'(w_from)]
                            && !r_placed[MW'(w_to)]) begin
                        r_cp    <= w_from;
                        r_cc    <= w_to;
                        r_state <= S_FOUT;
                    end else if (!r_vld && !w_issue) begin
                        r_state <= S_FOUT;
                    end
                end
                S_FOUT: begin
                    if (w_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_CYCLE;
                        r_opos    <= '0;
                        r_omod    <= '0;
                        r_ocp     <= r_cp;
                        r_occ     <= r_cc;
                        r_olast   <= 1'b1;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ST_ORDER;
                        r_opos    <= FIELD_W'(r_pos);
                        r_omod    <= FIELD_W'(r_order[r_pos[MW-1:0]]);
                        r_ocp     <= '0;
                        r_occ     <= '0;
                        r_olast   <= w_last;
                        r_pos     <= r_pos + NW'(1);
                        if (w_last) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.status         = r_ostatus;
    assign o_result.position       = r_opos;
    assign o_result.module_res     = r_omod;
    assign o_result.cycle_provider = r_ocp;
    assign o_result.cycle_consumer = r_occ;
    assign o_result.last           = r_olast;
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dto_pkg::*;

    // Limits and run shape
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int NUM_EDGES    = 256;
    localparam int NUM_MODULES  = 32;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;

    // operation code with no meaning; the block drops it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One expected result transaction, laid out like the output channel
    typedef struct {
        t_status    status;
        logic [4:0] position;
        logic [4:0] module_res;
        logic [4:0] cycle_provider;
        logic [4:0] cycle_consumer;
        logic       last;
    } t_expected;

    // Scoreboard: keeps its own copy of the graph and predicts every
    // transaction that the block should emit.
    class order_scoreboard;
        t_expected  expected_q[$];
        logic [4:0] edge_src[NUM_EDGES];
        logic [4:0] edge_dst[NUM_EDGES];
        int         edge_total;
        logic [31:0] uses_row[NUM_MODULES];
        bit         store_overflow;
        logic [5:0] module_count;
        int         errors;
        int         results_seen;

        function new();
            module_count = '0;
            errors       = 0;
            results_seen = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            edge_total     = 0;
            store_overflow = 0;
            foreach (uses_row[i]) uses_row[i] = '0;
        endfunction

        function int active_modules();
            return (module_count < NUM_MODULES) ? int'(module_count) : NUM_MODULES;
        endfunction

        function void push(t_status st, int pos, int md, int cp, int cc, bit lst);
            t_expected x;
            x.status         = st;
            x.position       = pos[4:0];
            x.module_res     = md[4:0];
            x.cycle_provider = cp[4:0];
            x.cycle_consumer = cc[4:0];
            x.last           = lst;
            expected_q.push_back(x);
        endfunction

        // Kahn ordering over the stored edges that lie inside the active set
        function void predict_order();
            int          n;
            int          in_deg[NUM_MODULES];
            int          order[NUM_MODULES];
            logic [31:0] placed;
            int          pos;
            int          pick;
            n = active_modules();
            if (n == 0) begin
                push(ST_EMPTY_OK, 0, 0, 0, 0, 1);
                return;
            end
            if (store_overflow) begin
                push(ST_FULL, 0, 0, 0, 0, 1);
                return;
            end
            foreach (in_deg[i]) in_deg[i] = 0;
            placed = '0;
            for (int e = 0; e < edge_total; e++)
                if (edge_src[e] < n && edge_dst[e] < n) in_deg[edge_dst[e]]++;
            for (pos = 0; pos < n; pos++) begin
                pick = n;
                for (int i = 0; i < n; i++) begin
                    if (!placed[i] && in_deg[i] == 0) begin
                        pick = i;
                        break;
                    end
                end
                if (pick == n) break;
                order[pos] = pick;
                placed[pick] = 1'b1;
                for (int j = 0; j < n; j++)
                    if (uses_row[pick][j] && !placed[j] && in_deg[j] > 0) in_deg[j]--;
            end
            if (pos < n) begin
                // stuck: first stored edge with both ends still unplaced
                for (int e = 0; e < edge_total; e++) begin
                    if (edge_src[e] < n && edge_dst[e] < n &&
                        !placed[edge_src[e]] && !placed[edge_dst[e]]) begin
                        push(ST_CYCLE, 0, 0, edge_src[e], edge_dst[e], 1);
                        return;
                    end
                end
                push(ST_CYCLE, 0, 0, 0, 0, 1);
                return;
            end
            for (int k = 0; k < n; k++)
                push(ST_ORDER, k, order[k], 0, 0, k == n - 1);
        endfunction

        // Called for every accepted input transaction
        function void note_input(logic [1:0] op, logic [4:0] p, logic [4:0] c);
            int n;
            n = active_modules();
            if (op == OP_ADD) begin
                if (p >= n || c >= n) begin
                    push(ST_RANGE, 0, 0, 0, 0, 1);
                end else if (uses_row[p][c]) begin
                    push(ST_DUP, 0, 0, 0, 0, 1);
                end else if (edge_total >= NUM_EDGES) begin
                    store_overflow = 1;
                    push(ST_FULL, 0, 0, 0, 0, 1);
                end else begin
                    edge_src[edge_total] = p;
                    edge_dst[edge_total] = c;
                    edge_total++;
                    uses_row[p][c] = 1'b1;
                    push(ST_ADDED, 0, 0, 0, 0, 1);
                end
            end else if (op == OP_COMPUTE) begin
                predict_order();
            end else if (op == OP_CLEAR) begin
                clear_graph();
                push(ST_CLEARED, 0, 0, 0, 0, 1);
            end
            // any other code is dropped by the block
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(logic [2:0] st, logic [4:0] pos, logic [4:0] md,
                          logic [4:0] cp, logic [4:0] cc, logic lst);
            t_expected x;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result status=%0d", st));
                return;
            end
            x = expected_q.pop_front();
            if (st !== x.status || pos !== x.position || md !== x.module_res ||
                cp !== x.cycle_provider || cc !== x.cycle_consumer || lst !== x.last)
                report($sformatf("got st=%0d pos=%0d mod=%0d cyc=%0d->%0d last=%0d, want st=%0d pos=%0d mod=%0d cyc=%0d->%0d last=%0d",
                                 st, pos, md, cp, cc, lst, x.status, x.position,
                                 x.module_res, x.cycle_provider, x.cycle_consumer, x.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    dto_in_if  item_if();
    dto_out_if result_if();

    dependency_topological_order uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if.sink),
        .o_result    (result_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    order_scoreboard sb;
    bit  idle_enable;     // random bubbles on both channels
    bit  hold_request;    // asks the receiver for one long back-pressure stretch
    int  cycle_count;
    int  stall_left;
    int  hold_left;
    int  computes_sent;

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: checks accepted results and plays ready. The long hold is
    // counted here so the sender keeps pushing and the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready)
                sb.check_result(result_if.status, result_if.position, result_if.module_res,
                                result_if.cycle_provider, result_if.cycle_consumer,
                                result_if.last);
            if (hold_request) begin
                hold_request = 0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Offer one transaction and wait for the handshake; optional bubble after.
    task send_item(logic [1:0] op, logic [4:0] p, logic [4:0] c);
        item_if.valid     <= 1'b1;
        item_if.operation <= op;
        item_if.provider  <= p;
        item_if.consumer  <= c;
        do @(posedge i_clk); while (!item_if.ready);
        sb.note_input(op, p, c);
        if (op == OP_COMPUTE) computes_sent++;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task wait_idle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only when the block is idle
    task write_count(logic [5:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.module_count = value;
        @(posedge i_clk);
    endtask

    // Random graph content for the active count: mostly forward edges so the
    // ordering completes, some back edges for cycles, some out-of-range noise.
    task random_phase(int num_items);
        int n;
        int pick;
        logic [4:0] p;
        logic [4:0] c;
        n = sb.active_modules();
        for (int k = 0; k < num_items; k++) begin
            pick = $urandom_range(0, 99);
            p = $urandom_range(0, 31);
            c = $urandom_range(0, 31);
            if (n > 0 && pick < 70) begin
                p = $urandom_range(0, n - 1);
                c = $urandom_range(0, n - 1);
                if (pick < 62 && p > c) begin
                    p = p ^ c;
                    c = p ^ c;
                    p = p ^ c;
                end
                send_item(OP_ADD, p, c);
            end else if (pick < 80) begin
                send_item(OP_ADD, p, c);
            end else if (pick < 92) begin
                send_item(OP_COMPUTE, p, c);
            end else if (pick < 95) begin
                send_item(OP_CLEAR, p, c);
            end else if (pick < 97) begin
                send_item(OP_UNUSED, p, c);
            end else begin
                send_item(OP_COMPUTE, 5'd0, 5'd0);
            end
        end
        send_item(OP_COMPUTE, 5'd0, 5'd0);
    endtask

    initial begin
        logic [5:0] phase_counts[6];
        sb = new();
        idle_enable       = 1;
        hold_request      = 0;
        cycle_count       = 0;
        stall_left        = 0;
        hold_left         = 0;
        computes_sent     = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        item_if.valid     = 1'b0;
        item_if.operation = '0;
        item_if.provider  = '0;
        item_if.consumer  = '0;
        result_if.ready   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // module count 0 after reset: empty set and out-of-range add
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        send_item(OP_ADD, 5'd0, 5'd0);
        write_count(6'd4);
        send_item(OP_ADD, 5'd0, 5'd1);
        send_item(OP_ADD, 5'd1, 5'd2);
        send_item(OP_ADD, 5'd0, 5'd1);     // duplicate
        send_item(OP_ADD, 5'd2, 5'd3);
        send_item(OP_COMPUTE, 5'd31, 5'd31);
        send_item(OP_COMPUTE, 5'd0, 5'd0); // graph kept across computes
        send_item(OP_ADD, 5'd3, 5'd0);     // closes a loop
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        send_item(OP_ADD, 5'd4, 5'd0);
        send_item(OP_ADD, 5'd0, 5'd31);
        send_item(OP_UNUSED, 5'd31, 5'd31); // dropped, no result
        send_item(OP_CLEAR, 5'd0, 5'd0);
        send_item(OP_ADD, 5'd2, 5'd2);     // self dependency
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        send_item(OP_CLEAR, 5'd0, 5'd0);
        // stale edges after the count is lowered
        write_count(6'd8);
        send_item(OP_ADD, 5'd6, 5'd7);
        send_item(OP_ADD, 5'd7, 5'd6);
        send_item(OP_ADD, 5'd5, 5'd1);
        write_count(6'd6);
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        write_count(6'd8);
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        // count above the module limit saturates
        write_count(6'd63);
        send_item(OP_ADD, 5'd31, 5'd0);
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        // fill the edge store, then overflow it; the fill also makes
        // the block back up under a long receiver hold
        send_item(OP_CLEAR, 5'd0, 5'd0);
        hold_request = 1;
        for (int k = 0; k < NUM_EDGES; k++)
            send_item(OP_ADD, k[7:3], {k[2:0], 2'b00} + 5'd1 + k[7:3]);
        send_item(OP_ADD, 5'd31, 5'd30);
        send_item(OP_COMPUTE, 5'd0, 5'd0);
        send_item(OP_CLEAR, 5'd0, 5'd0);
        send_item(OP_COMPUTE, 5'd0, 5'd0);

        // --- random, several count settings including the extremes ---
        phase_counts[0] = 6'd1;
        phase_counts[1] = 6'd2;
        phase_counts[2] = 6'd32;
        phase_counts[3] = 6'($urandom_range(3, 31));
        phase_counts[4] = 6'd63;
        phase_counts[5] = 6'd0;
        for (int ph = 0; ph < 6; ph++) begin
            write_count(phase_counts[ph]);
            send_item(OP_CLEAR, 5'd0, 5'd0);
            if (ph == 5) idle_enable = 0;   // no bubbles at the end
            random_phase(ph == 2 ? 50 : 25);
        end
        write_count(6'd12);
        random_phase(40);

        // --- drain ---
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered edge loads, duplicates, range refusals, store overflow, clears,");
        $display("%0d computes and %0d checked results over counts 0 to 63.",
                 computes_sent, sb.results_seen);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/dto_pkg.sv
src/dto_if.sv
src/dto_ram.sv
src/dto_cmd_fifo.sv
src/dto_front.sv
src/dto_back.sv
src/dependency_topological_order.sv
dv/testbench.sv
